FILE: rtl/scs1_pkg.sv
// Package for the scan code set 1 keyboard decoder.
// Holds decoder state and result types, mode codes and protocol bytes.
// No dependencies.
package scs1_pkg;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_E0   = 2'd1;
   localparam logic [1:0] MODE_SKIP = 2'd2;

   localparam logic [7:0] BYTE_E0      = 8'hE0;
   localparam logic [7:0] BYTE_E1      = 8'hE1;
   localparam logic [7:0] BYTE_LED_CMD = 8'hED;
   localparam logic [7:0] CODE_PRINT   = 8'hB7;
   localparam logic [7:0] CODE_PAUSE   = 8'hC5;
   localparam logic [7:0] CODE_HOME    = 8'hC7;

   localparam int MOD_W = 11;

   typedef struct packed {
      logic [1:0]       mode;
      logic [2:0]       skip_left;
      logic [7:0]       pending_code;
      logic             pending_is_break;
      logic [MOD_W-1:0] mods;
   } state_type;

   // count: 0, 1, or 3 (lock make: LED command, mask, press)
   typedef struct packed {
      logic [1:0]       count;
      logic             is_lock;
      logic [7:0]       code;
      logic [2:0]       mask;
      logic [MOD_W-1:0] mods;
   } result_type;

endpackage

FILE: rtl/scs1_decode.sv
// Combinational decode of one scan byte against the current decoder state.
// Produces the next state and the result group for the byte.
// Depends on scs1_pkg.
module scs1_decode (
   input  logic [7:0]             scan_byte,
   input  scs1_pkg::state_type    state_cur,
   output scs1_pkg::state_type    state_nxt,
   output scs1_pkg::result_type   result
);
   import scs1_pkg::*;

   logic [7:0] fin_code;
   logic       fin_brk;
   logic       fin_en;
   logic [6:0] low;
   logic       ext_brk;

   function automatic logic is_ext_key(input logic [7:0] v);
      logic r;
      case (v) inside
         8'h5B, 8'h1D, 8'h5C, 8'h38, 8'h5D, 8'h52, 8'h49, 8'h53,
         8'h4F, 8'h51, 8'h48, 8'h4B, 8'h50, 8'h4D, 8'h35, 8'h1C: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_keypad(input logic [7:0] v);
      logic r;
      case (v) inside
         [8'h47:8'h49], [8'h4B:8'h4D], [8'h4F:8'h53]: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   assign ext_brk = scan_byte > 8'h80;
   assign low     = scan_byte[6:0];

   always_comb begin
      state_nxt = state_cur;
      fin_en    = 1'b0;
      fin_code  = 8'h00;
      fin_brk   = 1'b0;
      case (state_cur.mode)
         MODE_SKIP: begin
            if (state_cur.skip_left > 3'd1) begin
               state_nxt.skip_left = state_cur.skip_left - 3'd1;
            end else begin
               state_nxt.skip_left = 3'd0;
               state_nxt.mode      = MODE_IDLE;
               fin_en   = 1'b1;
               fin_code = state_cur.pending_code;
               fin_brk  = state_cur.pending_is_break;
            end
         end
         MODE_E0: begin
            state_nxt.mode = MODE_IDLE;
            if (scan_byte == 8'h47 || scan_byte == CODE_HOME) begin
               fin_en   = 1'b1;
               fin_code = CODE_HOME;
               fin_brk  = scan_byte == CODE_HOME;
            end else if (scan_byte == 8'h2A || scan_byte == CODE_PRINT) begin
               state_nxt.pending_code     = CODE_PRINT;
               state_nxt.pending_is_break = scan_byte == CODE_PRINT;
               state_nxt.mode             = MODE_SKIP;
               state_nxt.skip_left        = 3'd2;
            end else begin
               fin_en  = 1'b1;
               fin_brk = ext_brk;
               if (ext_brk) begin
                  fin_code = is_ext_key({1'b0, low}) ? {1'b1, low} : 8'h00;
               end else begin
                  fin_code = is_ext_key(scan_byte) ? (scan_byte | 8'h80) : 8'h00;
               end
            end
         end
         default: begin
            if (scan_byte == BYTE_E0) begin
               state_nxt.mode = MODE_E0;
            end else if (scan_byte == BYTE_E1) begin
               state_nxt.pending_code     = CODE_PAUSE;
               state_nxt.pending_is_break = 1'b0;
               state_nxt.mode             = MODE_SKIP;
               state_nxt.skip_left        = 3'd5;
            end else begin
               fin_en = 1'b1;
               case (scan_byte) inside
                  [8'h54:8'h56]: fin_code = 8'h00;
                  [8'h01:8'h58]: fin_code = scan_byte;
                  [8'hD4:8'hD6]: begin
                     fin_code = 8'h00;
                     fin_brk  = 1'b1;
                  end
                  [8'h81:8'hD8]: begin
                     fin_code = {1'b0, low};
                     fin_brk  = 1'b1;
                  end
                  default: fin_code = 8'h00;
               endcase
            end
         end
      endcase

      // modifier / lock update and result forming
      result.count   = 2'd0;
      result.is_lock = 1'b0;
      result.code    = fin_code;
      if (fin_en) begin
         case (fin_code)
            8'h45, 8'h3A, 8'h46: begin
               if (!fin_brk) begin
                  result.is_lock = 1'b1;
                  case (fin_code)
                     8'h45:   state_nxt.mods[8]  = ~state_cur.mods[8];
                     8'h3A:   state_nxt.mods[9]  = ~state_cur.mods[9];
                     default: state_nxt.mods[10] = ~state_cur.mods[10];
                  endcase
               end
            end
            8'h2A: state_nxt.mods[0] = ~fin_brk;
            8'h1D: state_nxt.mods[1] = ~fin_brk;
            8'hDB: state_nxt.mods[2] = ~fin_brk;
            8'h38: state_nxt.mods[3] = ~fin_brk;
            8'h36: state_nxt.mods[4] = ~fin_brk;
            8'h9D: state_nxt.mods[5] = ~fin_brk;
            8'hDC: state_nxt.mods[6] = ~fin_brk;
            8'hB8: state_nxt.mods[7] = ~fin_brk;
            default: ;
         endcase
         if (result.is_lock) begin
            result.count = 2'd3;
         end else if (!fin_brk && !(is_keypad(fin_code) && !state_nxt.mods[8])) begin
            result.count = 2'd1;
         end
      end
      result.mods = state_nxt.mods;
      result.mask = {state_nxt.mods[9], state_nxt.mods[8], state_nxt.mods[10]};
   end

endmodule

FILE: rtl/scan_set1_keyboard_decoder.sv
// Top level of the scan code set 1 keyboard decoder.
// Holds decoder state and the result buffer; decode in scs1_decode.
// Depends on scs1_pkg and scs1_decode.
//
//  channel | dir | tdata                         | tuser   | tlast
//  req     | in  | [7:0] scan_byte               | -       | -
//  rsp     | out | [7:0] code_value [18:8] mods  | [0] kind| last
//
// One result beat per cycle while rsp_tready is high. A byte is decoded in the
// cycle it is taken and its 0, 1 or 3 results land in the buffer; a lock make
// holds the buffer for three beats, so the buffer drain sets the byte rate.
// A new byte is taken while the buffer is empty or its last beat is leaving.
// Synchronous reset clears state and empties the buffer.
module scan_set1_keyboard_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] code_value, [18:8] modifier_bits, pad
   output logic [0:0]  rsp_tuser,   // [0] kind
   output logic        rsp_tlast
);
   import scs1_pkg::*;

   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic [1:0] left_ff, left_in;
   logic       req_take, rsp_take;
   logic [7:0] code_out;

   scs1_decode u_decode (
      .scan_byte (req_tdata),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (res_in)
   );

   assign rsp_tvalid = left_ff != 2'd0;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_tready = (left_ff == 2'd0) || (left_ff == 2'd1 && rsp_tready);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      left_in = left_ff;
      if (rsp_take) begin
         left_in = left_ff - 2'd1;
      end
      if (req_take) begin
         left_in = res_in.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         left_ff  <= 2'd0;
      end else begin
         left_ff <= left_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      case (left_ff)
         2'd3:    code_out = BYTE_LED_CMD;
         2'd2:    code_out = {5'd0, res_ff.mask};
         default: code_out = res_ff.code;
      endcase
   end

   assign rsp_tdata    = {5'd0, res_ff.mods, code_out};
   assign rsp_tuser[0] = res_ff.is_lock && (left_ff != 2'd1);
   assign rsp_tlast    = left_ff == 2'd1;

endmodule

FILE: bench/tb_scan_set1_keyboard_decoder.sv
`timescale 1ns / 100ps
// Self-checking bench for scan_set1_keyboard_decoder: scripted and random scan
// bytes go in; response beats are checked against a built-in decoder model.
// Depends on scs1_pkg and the decoder RTL.
module tb_scan_set1_keyboard_decoder;
   import scs1_pkg::*;

   localparam logic       KIND_PRESS  = 1'b0;
   localparam logic       KIND_HOST   = 1'b1;
   localparam logic [7:0] KEY_CODE_NONE = 8'h00;
   localparam logic [7:0] KEY_HOME_MK = 8'h47;
   localparam logic [7:0] KEY_PRT_MK  = 8'h2A;
   localparam int         STALL_LIMIT = 4000;
   localparam int         SCRIPT_LEN  = 32;
   localparam int         PHASE_BYTES = 125;

   typedef struct packed {
      logic             kind;
      logic [7:0]       code;
      logic [MOD_W-1:0] mods;
      logic             last;
   } key_beat_type;

   typedef struct packed {
      logic [7:0]       scan;
      logic             typed;
      logic [7:0]       code;
      logic [MOD_W-1:0] mods;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   // decoder model state
   logic [1:0]       key_mode = MODE_IDLE;
   logic [2:0]       skip_cnt = 3'd0;
   logic [7:0]       pend_code = 8'h00;
   logic             pend_brk = 1'b0;
   logic [MOD_W-1:0] key_mods = '0;

   key_beat_type decoded_q[$];
   key_beat_type byte_beats[$];
   int        mismatch_count = 0;
   int        bytes_sent = 0;
   int        quiet_cycles = 0;
   int        send_gap_pct = 0;
   int        stall_pct = 0;

   logic [7:0] ext_keys [16] = '{8'h5B, 8'h1D, 8'h5C, 8'h38, 8'h5D, 8'h52, 8'h49, 8'h53,
                                 8'h4F, 8'h51, 8'h48, 8'h4B, 8'h50, 8'h4D, 8'h35, 8'h1C};
   logic [7:0] mod_keys [4]  = '{8'h2A, 8'h1D, 8'h38, 8'h36};
   logic [7:0] lock_keys [3] = '{8'h45, 8'h3A, 8'h46};

   script_row_type script [SCRIPT_LEN] = '{
      '{8'h00, 1'b1, KEY_CODE_NONE, 11'h000},
      '{8'hFF, 1'b1, KEY_CODE_NONE, 11'h000},
      '{8'h01, 1'b1, 8'h01, 11'h000},
      '{8'h58, 1'b1, 8'h58, 11'h000},
      '{8'h2A, 1'b1, 8'h2A, 11'h001},
      '{8'h1E, 1'b0, 8'h00, 11'h000},
      '{8'hAA, 1'b0, 8'h00, 11'h000},
      '{8'h47, 1'b0, 8'h00, 11'h000},   // keypad 7, num lock off
      '{8'h45, 1'b0, 8'h00, 11'h000},
      '{8'h47, 1'b0, 8'h00, 11'h000},
      '{8'h3A, 1'b0, 8'h00, 11'h000},
      '{8'h46, 1'b0, 8'h00, 11'h000},
      '{BYTE_E0, 1'b0, 8'h00, 11'h000},
      '{8'h1D, 1'b0, 8'h00, 11'h000},
      '{BYTE_E0, 1'b0, 8'h00, 11'h000},
      '{8'h9D, 1'b0, 8'h00, 11'h000},
      '{BYTE_E0, 1'b0, 8'h00, 11'h000},
      '{KEY_HOME_MK, 1'b0, 8'h00, 11'h000},
      '{BYTE_E0, 1'b0, 8'h00, 11'h000},
      '{CODE_HOME, 1'b0, 8'h00, 11'h000},
      '{BYTE_E0, 1'b0, 8'h00, 11'h000},
      '{KEY_PRT_MK, 1'b0, 8'h00, 11'h000},
      '{BYTE_E0, 1'b0, 8'h00, 11'h000},
      '{8'h37, 1'b0, 8'h00, 11'h000},
      '{BYTE_E1, 1'b0, 8'h00, 11'h000},
      '{8'h1D, 1'b0, 8'h00, 11'h000},
      '{8'h45, 1'b0, 8'h00, 11'h000},
      '{BYTE_E1, 1'b0, 8'h00, 11'h000},
      '{8'h9D, 1'b0, 8'h00, 11'h000},
      '{8'hC5, 1'b0, 8'h00, 11'h000},
      '{8'hD9, 1'b0, 8'h00, 11'h000},
      '{8'h80, 1'b0, 8'h00, 11'h000}
   };

   scan_set1_keyboard_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] scan_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] code_value, [18:8] modifier_bits, pad
      .rsp_tuser  (rsp_tuser),    // [0] kind
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int mod_index(input logic [7:0] code);
      case (code)
         8'h2A: return 0;
         8'h1D: return 1;
         8'hDB: return 2;
         8'h38: return 3;
         8'h36: return 4;
         8'h9D: return 5;
         8'hDC: return 6;
         8'hB8: return 7;
         8'h45: return 8;
         8'h3A: return 9;
         8'h46: return 10;
         default: return -1;
      endcase
   endfunction

   function automatic bit keypad_digit(input logic [7:0] code);
      return (code >= 8'h47 && code <= 8'h49) || (code >= 8'h4B && code <= 8'h4D) ||
             (code >= 8'h4F && code <= 8'h53);
   endfunction

   function automatic bit extended_key(input logic [7:0] low);
      foreach (ext_keys[i])
         if (ext_keys[i] == low) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void add_beat(input logic kind, input logic [7:0] code);
      byte_beats.push_back('{kind, code, key_mods, 1'b0});
   endfunction

   // modifier / lock update, then LED bytes and the press beat
   function automatic void apply_key(input logic [7:0] code, input bit brk);
      int idx;
      idx = mod_index(code);
      if (idx >= 8) begin
         if (!brk) begin
            key_mods[idx] = ~key_mods[idx];
            add_beat(KIND_HOST, BYTE_LED_CMD);
            add_beat(KIND_HOST, {5'b0, key_mods[9], key_mods[8], key_mods[10]});
         end
      end else if (idx >= 0) begin
         key_mods[idx] = !brk;
      end
      if (keypad_digit(code) && !key_mods[8]) brk = 1'b1;
      if (!brk) add_beat(KIND_PRESS, code);
      if (byte_beats.size() > 0) byte_beats[byte_beats.size()-1].last = 1'b1;
   endfunction

   function automatic void decode_scan(input logic [7:0] b);
      logic [7:0] low;
      bit         brk;
      byte_beats.delete();
      if (key_mode == MODE_SKIP) begin
         if (skip_cnt > 3'd1) begin
            skip_cnt = skip_cnt - 3'd1;
         end else begin
            skip_cnt = 3'd0;
            key_mode = MODE_IDLE;
            apply_key(pend_code, pend_brk);
         end
      end else if (key_mode == MODE_E0) begin
         key_mode = MODE_IDLE;
         if (b == KEY_HOME_MK) begin
            apply_key(CODE_HOME, 1'b0);
         end else if (b == CODE_HOME) begin
            apply_key(CODE_HOME, 1'b1);
         end else if (b == KEY_PRT_MK || b == CODE_PRINT) begin
            pend_code = CODE_PRINT;
            pend_brk  = (b == CODE_PRINT);
            key_mode  = MODE_SKIP;
            skip_cnt  = 3'd2;
         end else begin
            brk = (b > 8'h80);
            low = brk ? b - 8'h80 : b;
            apply_key(extended_key(low) ? (8'h80 | low) : KEY_CODE_NONE, brk);
         end
      end else if (b == BYTE_E0) begin
         key_mode = MODE_E0;
      end else if (b == BYTE_E1) begin
         pend_code = CODE_PAUSE;
         pend_brk  = 1'b0;
         key_mode  = MODE_SKIP;
         skip_cnt  = 3'd5;
      end else if (b >= 8'h01 && b <= 8'h58) begin
         apply_key((b >= 8'h54 && b <= 8'h56) ? KEY_CODE_NONE : b, 1'b0);
      end else if (b >= 8'h81 && b <= 8'hD8) begin
         low = b - 8'h80;
         apply_key((low >= 8'h54 && low <= 8'h56) ? KEY_CODE_NONE : low, 1'b1);
      end else begin
         apply_key(KEY_CODE_NONE, 1'b0);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [23:0] seen,
                                  input logic [23:0] want);
      if (mismatch_count < 40)
         $display("%0t: %s mismatch: got %h want %h", $time, what, seen, want);
      mismatch_count++;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input logic [7:0] code,
                            input logic [MOD_W-1:0] mods);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_scan(b);
      if (typed)
         decoded_q.push_back('{KIND_PRESS, code, mods, 1'b1});
      else
         foreach (byte_beats[i]) decoded_q.push_back(byte_beats[i]);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
   endtask

   // mostly well-formed sequences with random content, some raw noise
   task automatic send_random_group();
      int pick;
      logic [7:0] key;
      pick = $urandom_range(99);
      if (pick < 30) begin
         key = 8'($urandom_range(8'h58, 8'h01));
         send_byte(key, 0, 0, 0);
         if ($urandom_range(1)) send_byte(key | 8'h80, 0, 0, 0);
      end else if (pick < 42) begin
         send_byte(8'($urandom_range(8'hD8, 8'h81)), 0, 0, 0);
      end else if (pick < 58) begin
         send_byte(BYTE_E0, 0, 0, 0);
         if ($urandom_range(4) != 0)
            key = ext_keys[$urandom_range(15)] | ($urandom_range(1) ? 8'h80 : 8'h00);
         else
            key = 8'($urandom_range(255));
         send_byte(key, 0, 0, 0);
      end else if (pick < 66) begin
         key = lock_keys[$urandom_range(2)] | ($urandom_range(3) == 0 ? 8'h80 : 8'h00);
         send_byte(key, 0, 0, 0);
      end else if (pick < 74) begin
         if ($urandom_range(1)) send_byte(BYTE_E0, 0, 0, 0);
         key = mod_keys[$urandom_range(3)] | ($urandom_range(1) ? 8'h80 : 8'h00);
         send_byte(key, 0, 0, 0);
      end else if (pick < 80) begin
         send_byte(BYTE_E0, 0, 0, 0);
         send_byte($urandom_range(1) ? KEY_PRT_MK : CODE_PRINT, 0, 0, 0);
         repeat (2) send_byte(8'($urandom_range(255)), 0, 0, 0);
      end else if (pick < 86) begin
         send_byte(BYTE_E1, 0, 0, 0);
         repeat (5) send_byte(8'($urandom_range(255)), 0, 0, 0);
      end else begin
         send_byte(8'($urandom_range(255)), 0, 0, 0);
      end
   endtask

   always @(posedge clock) begin : response_check
      key_beat_type want;
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, 24'h0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tuser[0] !== want.kind)
               report_mismatch("kind", 24'(rsp_tuser), 24'(want.kind));
            if (rsp_tdata[7:0] !== want.code)
               report_mismatch("code_value", 24'(rsp_tdata[7:0]), 24'(want.code));
            if (rsp_tdata[18:8] !== want.mods)
               report_mismatch("modifier_bits", 24'(rsp_tdata[18:8]), 24'(want.mods));
            if (rsp_tdata[23:19] !== 5'd0) report_mismatch("tdata pad", rsp_tdata, 24'h0);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 24'(rsp_tlast), 24'(want.last));
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_byte(script[i].scan, script[i].typed, script[i].code, script[i].mods);

      while (bytes_sent < SCRIPT_LEN + PHASE_BYTES) send_random_group();

      drain_results();
      send_gap_pct = 49;
      stall_pct    = 0;
      while (bytes_sent < SCRIPT_LEN + 2 * PHASE_BYTES) send_random_group();

      send_gap_pct = 0;
      stall_pct    = 49;
      while (bytes_sent < SCRIPT_LEN + 3 * PHASE_BYTES) send_random_group();

      drain_results();
      send_gap_pct = 34;
      stall_pct    = 34;
      while (bytes_sent < SCRIPT_LEN + 4 * PHASE_BYTES) send_random_group();

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && decoded_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
